// ===== src/tpi_pkg.sv =====
// Shared types, constants and tables of the turtle path interpreter.
package tpi_pkg;

  localparam int STACK_DEPTH  = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int STACK_AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LEVEL_W      = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W        = 5;

  localparam logic [14:0] FULL_TURN = 15'd23040;
  localparam logic [29:0] GAIN_Q30  = 30'd652032875;
  localparam logic signed [25:0] DEG90  = 26'sd5898240;
  localparam logic signed [25:0] DEG180 = 26'sd11796480;
  localparam logic signed [25:0] DEG270 = 26'sd17694720;
  localparam logic signed [25:0] DEG360 = 26'sd23592960;

  localparam logic [7:0] CH_FWD   = 8'h46;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PUSH  = 8'h5B;
  localparam logic [7:0] CH_POP   = 8'h5D;

  localparam logic [3:0] REG_TURN  = 4'd0;
  localparam logic [3:0] REG_STEP  = 4'd1;
  localparam logic [3:0] REG_STX   = 4'd2;
  localparam logic [3:0] REG_STY   = 4'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OVF  = 2'd1;
  localparam logic [1:0] ERR_UNF  = 2'd2;

  typedef enum logic [2:0] {
    SYM_NONE, SYM_FWD, SYM_PLUS, SYM_MINUS, SYM_PUSH, SYM_POP
  } sym_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_NEW, OP_MOVE, OP_ERR_OVF, OP_ERR_UNF, OP_PUSH,
    OP_POP, OP_POP_LOAD, OP_TURN_L, OP_TURN_R, OP_CSET, OP_CITER, OP_CFIN
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NEW, ST_OP, ST_POPL, ST_CSET, ST_CITER, ST_CFIN
  } state_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    sym_t sym;
    logic new_drawing;
    logic full;
    logic empty;
    logic out_free;
    logic cdone;
  } dp_status_t;

  // CORDIC arc tangents in degrees, Q.16, rounded.
  function automatic logic signed [22:0] atan_q16(input logic [CNT_W-1:0] i);
    logic signed [22:0] v;
    case (i)
      5'd0:  v = 23'sd2949120;
      5'd1:  v = 23'sd1740967;
      5'd2:  v = 23'sd919879;
      5'd3:  v = 23'sd466945;
      5'd4:  v = 23'sd234379;
      5'd5:  v = 23'sd117305;
      5'd6:  v = 23'sd58666;
      5'd7:  v = 23'sd29335;
      5'd8:  v = 23'sd14668;
      5'd9:  v = 23'sd7334;
      5'd10: v = 23'sd3667;
      5'd11: v = 23'sd1833;
      5'd12: v = 23'sd917;
      5'd13: v = 23'sd458;
      5'd14: v = 23'sd229;
      5'd15: v = 23'sd115;
      5'd16: v = 23'sd57;
      5'd17: v = 23'sd29;
      5'd18: v = 23'sd14;
      5'd19: v = 23'sd7;
      5'd20: v = 23'sd4;
      5'd21: v = 23'sd2;
      5'd22: v = 23'sd1;
      default: v = 23'sd0;
    endcase
    return v;
  endfunction

  // Q16.8 position to whole pixels, truncated toward zero.
  function automatic logic signed [15:0] pixel_of(input logic signed [23:0] p);
    logic signed [15:0] q;
    q = p[23:8];
    if (p[23] && (p[7:0] != 8'd0)) begin
      q = q + 16'sd1;
    end
    return q;
  endfunction

endpackage

// ===== src/tpi_if.sv =====
// Channel interfaces: symbol input, segment output and register write port.
interface tpi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       new_drawing;
  modport source (output valid, symbol, new_drawing, input ready);
  modport sink (input valid, symbol, new_drawing, output ready);
endinterface

interface tpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_from;
  logic signed [15:0] y_from;
  logic signed [15:0] x_to;
  logic signed [15:0] y_to;
  logic [1:0]         stack_error;
  modport source (output valid, x_from, y_from, x_to, y_to, stack_error, input ready);
  modport sink (input valid, x_from, y_from, x_to, y_to, stack_error, output ready);
endinterface

interface tpi_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  idx;
  logic [15:0] wdata;
  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

// ===== src/turtle_path_interpreter_top.sv =====
// Top level of the turtle path interpreter: controller, datapath and channels.
//
//  channel | dir | word carries
//  in_ch   | in  | symbol, new_drawing
//  out_ch  | out | x_from, y_from, x_to, y_to, stack_error
//  cfg_ch  | in  | idx (register 0..3), wdata; always ready
//
// One word at a time. A turn runs the shared CORDIC iteration loop, and a restore
// loads the saved entry first and then runs the same loop. A result word waits in
// an output register; the next symbol is accepted meanwhile, and only a further
// result stalls until out_ch is ready.
// Synchronous active-low reset restores register defaults and the start state.
module turtle_path_interpreter_top (
  input logic       clk,
  input logic       rst_n,
  tpi_in_if.sink    in_ch,
  tpi_out_if.source out_ch,
  tpi_cfg_if.sink   cfg_ch
);

  tpi_pkg::ctrl_cmd_t  cmd;
  tpi_pkg::dp_status_t st;

  assign cfg_ch.ready = 1'b1;

  tpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  tpi_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_symbol       (in_ch.symbol),
    .in_new_drawing  (in_ch.new_drawing),
    .cfg_we          (cfg_ch.valid),
    .cfg_idx         (cfg_ch.idx),
    .cfg_wdata       (cfg_ch.wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_x_from      (out_ch.x_from),
    .out_y_from      (out_ch.y_from),
    .out_x_to        (out_ch.x_to),
    .out_y_to        (out_ch.y_to),
    .out_stack_error (out_ch.stack_error)
  );

endmodule

// ===== src/tpi_ctrl.sv =====
// Controller state machine that sequences each turtle symbol.
module tpi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tpi_pkg::dp_status_t st,
  output tpi_pkg::ctrl_cmd_t  cmd
);

  tpi_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = tpi_pkg::OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      tpi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = tpi_pkg::OP_LATCH;
          state_nxt = tpi_pkg::ST_NEW;
        end
      end
      tpi_pkg::ST_NEW: begin
        if (st.new_drawing) begin
          cmd.op = tpi_pkg::OP_NEW;
        end
        state_nxt = tpi_pkg::ST_OP;
      end
      tpi_pkg::ST_OP: begin
        case (st.sym)
          tpi_pkg::SYM_FWD: begin
            if (st.out_free) begin
              cmd.op    = tpi_pkg::OP_MOVE;
              state_nxt = tpi_pkg::ST_IDLE;
            end
          end
          tpi_pkg::SYM_PLUS: begin
            cmd.op    = tpi_pkg::OP_TURN_L;
            state_nxt = tpi_pkg::ST_CSET;
          end
          tpi_pkg::SYM_MINUS: begin
            cmd.op    = tpi_pkg::OP_TURN_R;
            state_nxt = tpi_pkg::ST_CSET;
          end
          tpi_pkg::SYM_PUSH: begin
            if (!st.full) begin
              cmd.op    = tpi_pkg::OP_PUSH;
              state_nxt = tpi_pkg::ST_IDLE;
            end else if (st.out_free) begin
              cmd.op    = tpi_pkg::OP_ERR_OVF;
              state_nxt = tpi_pkg::ST_IDLE;
            end
          end
          tpi_pkg::SYM_POP: begin
            if (!st.empty) begin
              cmd.op    = tpi_pkg::OP_POP;
              state_nxt = tpi_pkg::ST_POPL;
            end else if (st.out_free) begin
              cmd.op    = tpi_pkg::OP_ERR_UNF;
              state_nxt = tpi_pkg::ST_IDLE;
            end
          end
          default: state_nxt = tpi_pkg::ST_IDLE;
        endcase
      end
      tpi_pkg::ST_POPL: begin
        cmd.op    = tpi_pkg::OP_POP_LOAD;
        state_nxt = tpi_pkg::ST_CSET;
      end
      tpi_pkg::ST_CSET: begin
        cmd.op    = tpi_pkg::OP_CSET;
        state_nxt = tpi_pkg::ST_CITER;
      end
      tpi_pkg::ST_CITER: begin
        cmd.op = tpi_pkg::OP_CITER;
        if (st.cdone) begin
          state_nxt = tpi_pkg::ST_CFIN;
        end
      end
      tpi_pkg::ST_CFIN: begin
        cmd.op    = tpi_pkg::OP_CFIN;
        state_nxt = tpi_pkg::ST_IDLE;
      end
      default: state_nxt = tpi_pkg::ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == tpi_pkg::ST_IDLE))
    else $error("input taken outside idle");
  a_latch_new: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == tpi_pkg::ST_NEW))
    else $error("accepted word not sequenced");
  a_cset_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tpi_pkg::ST_CSET) |=> (state_r == tpi_pkg::ST_CITER))
    else $error("CORDIC setup not followed by iterations");

endmodule

// ===== src/tpi_dp.sv =====
// Datapath: registers, turtle state, save stack, CORDIC unit and output word.
module tpi_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  tpi_pkg::ctrl_cmd_t  cmd,
  output tpi_pkg::dp_status_t st,
  input  logic [7:0]          in_symbol,
  input  logic                in_new_drawing,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_idx,
  input  logic [15:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_x_from,
  output logic signed [15:0]  out_y_from,
  output logic signed [15:0]  out_x_to,
  output logic signed [15:0]  out_y_to,
  output logic [1:0]          out_stack_error
);

  logic [14:0] turn_r;
  logic [9:0]  step_len_r;
  logic [11:0] start_x_r, start_y_r;

  logic [7:0]  sym_r;
  logic        nd_r;

  logic signed [23:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [14:0]        head_r, head_nxt;
  logic signed [23:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [tpi_pkg::LEVEL_W-1:0] lvl_r, lvl_nxt;

  logic signed [31:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [25:0] cz_r, cz_nxt;
  logic               neg_r, neg_nxt;
  logic [tpi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic               ov_r, ov_nxt;
  logic signed [15:0] oxf_r, oxf_nxt, oyf_r, oyf_nxt, oxt_r, oxt_nxt, oyt_r, oyt_nxt;
  logic [1:0]         oerr_r, oerr_nxt;

  logic [46:0] mem [tpi_pkg::STACK_DEPTH];
  logic [46:0] rdata_r;
  logic [tpi_pkg::LEVEL_W-1:0] lvl_m1;
  logic [tpi_pkg::STACK_AW-1:0] rd_addr, wr_addr;

  logic [14:0] turn_red, head_sum, head_dif;
  logic [15:0] sum16;
  logic signed [23:0] nx, ny;
  logic signed [25:0] hq;
  logic [39:0] prod;
  logic signed [31:0] xs, ys, xn, yn, xr, yr;
  logic signed [22:0] at;

  assign lvl_m1  = lvl_r - {{(tpi_pkg::LEVEL_W-1){1'b0}}, 1'b1};
  assign rd_addr = lvl_m1[tpi_pkg::STACK_AW-1:0];
  assign wr_addr = lvl_r[tpi_pkg::STACK_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.op == tpi_pkg::OP_PUSH) begin
      mem[wr_addr] <= {tpi_pkg::pixel_of(pos_x_r), tpi_pkg::pixel_of(pos_y_r), head_r};
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r     <= 15'd5760;
      step_len_r <= 10'd10;
      start_x_r  <= 12'd960;
      start_y_r  <= 12'd540;
    end else if (cfg_we) begin
      case (cfg_idx)
        tpi_pkg::REG_TURN: turn_r     <= cfg_wdata[14:0];
        tpi_pkg::REG_STEP: step_len_r <= cfg_wdata[9:0];
        tpi_pkg::REG_STX:  start_x_r  <= cfg_wdata[11:0];
        tpi_pkg::REG_STY:  start_y_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tpi_pkg::OP_LATCH) begin
      sym_r <= in_symbol;
      nd_r  <= in_new_drawing;
    end
  end

  // Turn increment and heading arithmetic, all below two full turns.
  always_comb begin
    turn_red = (turn_r >= tpi_pkg::FULL_TURN) ? (turn_r - tpi_pkg::FULL_TURN) : turn_r;
    sum16    = {1'b0, head_r} + {1'b0, turn_red};
    head_sum = (sum16 >= {1'b0, tpi_pkg::FULL_TURN}) ?
               sum16[14:0] - tpi_pkg::FULL_TURN : sum16[14:0];
    sum16    = {1'b0, head_r} + {1'b0, tpi_pkg::FULL_TURN} - {1'b0, turn_red};
    head_dif = (sum16 >= {1'b0, tpi_pkg::FULL_TURN}) ?
               sum16[14:0] - tpi_pkg::FULL_TURN : sum16[14:0];
  end

  assign nx   = pos_x_r + dx_r;
  assign ny   = pos_y_r + dy_r;
  assign hq   = $signed({1'b0, head_r, 10'd0});
  assign prod = {30'd0, step_len_r} * {10'd0, tpi_pkg::GAIN_Q30};
  assign xs   = cx_r >>> cnt_r;
  assign ys   = cy_r >>> cnt_r;
  assign at   = tpi_pkg::atan_q16(cnt_r);
  assign xn   = neg_r ? -cx_r : cx_r;
  assign yn   = neg_r ? -cy_r : cy_r;
  assign xr   = (xn + 32'sd128) >>> 8;
  assign yr   = (yn + 32'sd128) >>> 8;

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    head_nxt  = head_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    lvl_nxt   = lvl_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    cz_nxt    = cz_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    oxf_nxt   = oxf_r;
    oyf_nxt   = oyf_r;
    oxt_nxt   = oxt_r;
    oyt_nxt   = oyt_r;
    oerr_nxt  = oerr_r;
    case (cmd.op)
      tpi_pkg::OP_NEW: begin
        pos_x_nxt = {4'd0, start_x_r, 8'd0};
        pos_y_nxt = {4'd0, start_y_r, 8'd0};
        head_nxt  = 15'd0;
        dx_nxt    = {6'd0, step_len_r, 8'd0};
        dy_nxt    = 24'sd0;
        lvl_nxt   = '0;
      end
      tpi_pkg::OP_MOVE: begin
        oxf_nxt   = tpi_pkg::pixel_of(pos_x_r);
        oyf_nxt   = tpi_pkg::pixel_of(pos_y_r);
        oxt_nxt   = tpi_pkg::pixel_of(nx);
        oyt_nxt   = tpi_pkg::pixel_of(ny);
        oerr_nxt  = tpi_pkg::ERR_NONE;
        ov_nxt    = 1'b1;
        pos_x_nxt = nx;
        pos_y_nxt = ny;
      end
      tpi_pkg::OP_ERR_OVF, tpi_pkg::OP_ERR_UNF: begin
        oxf_nxt  = 16'sd0;
        oyf_nxt  = 16'sd0;
        oxt_nxt  = 16'sd0;
        oyt_nxt  = 16'sd0;
        oerr_nxt = (cmd.op == tpi_pkg::OP_ERR_OVF) ? tpi_pkg::ERR_OVF : tpi_pkg::ERR_UNF;
        ov_nxt   = 1'b1;
      end
      tpi_pkg::OP_PUSH: lvl_nxt = lvl_r + {{(tpi_pkg::LEVEL_W-1){1'b0}}, 1'b1};
      tpi_pkg::OP_POP:  lvl_nxt = lvl_m1;
      tpi_pkg::OP_POP_LOAD: begin
        pos_x_nxt = {rdata_r[46:31], 8'd0};
        pos_y_nxt = {rdata_r[30:15], 8'd0};
        head_nxt  = rdata_r[14:0];
      end
      tpi_pkg::OP_TURN_L: head_nxt = head_sum;
      tpi_pkg::OP_TURN_R: head_nxt = head_dif;
      tpi_pkg::OP_CSET: begin
        // Fold the heading into [-90, 90] degrees; the far half is negated at the end.
        neg_nxt = 1'b0;
        cz_nxt  = hq;
        if (hq > tpi_pkg::DEG90 && hq < tpi_pkg::DEG270) begin
          cz_nxt  = hq - tpi_pkg::DEG180;
          neg_nxt = 1'b1;
        end else if (hq >= tpi_pkg::DEG270) begin
          cz_nxt = hq - tpi_pkg::DEG360;
        end
        cx_nxt  = $signed({6'd0, prod[39:14]});
        cy_nxt  = 32'sd0;
        cnt_nxt = '0;
      end
      tpi_pkg::OP_CITER: begin
        if (!cz_r[25]) begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - 26'(at);
        end else begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + 26'(at);
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      tpi_pkg::OP_CFIN: begin
        dx_nxt = xr[23:0];
        dy_nxt = yr[23:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= 24'sd245760;
      pos_y_r <= 24'sd138240;
      head_r  <= 15'd0;
      dx_r    <= 24'sd2560;
      dy_r    <= 24'sd0;
      lvl_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      head_r  <= head_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      lvl_r   <= lvl_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    oxf_r  <= oxf_nxt;
    oyf_r  <= oyf_nxt;
    oxt_r  <= oxt_nxt;
    oyt_r  <= oyt_nxt;
    oerr_r <= oerr_nxt;
  end

  always_comb begin
    st.sym = tpi_pkg::SYM_NONE;
    case (sym_r)
      tpi_pkg::CH_FWD:   st.sym = tpi_pkg::SYM_FWD;
      tpi_pkg::CH_PLUS:  st.sym = tpi_pkg::SYM_PLUS;
      tpi_pkg::CH_MINUS: st.sym = tpi_pkg::SYM_MINUS;
      tpi_pkg::CH_PUSH:  st.sym = tpi_pkg::SYM_PUSH;
      tpi_pkg::CH_POP:   st.sym = tpi_pkg::SYM_POP;
      default:           st.sym = tpi_pkg::SYM_NONE;
    endcase
    st.new_drawing = nd_r;
    st.full        = (lvl_r == tpi_pkg::LEVEL_W'(tpi_pkg::STACK_DEPTH));
    st.empty       = (lvl_r == '0);
    st.out_free    = !ov_r || out_ready;
    st.cdone       = (cnt_r == tpi_pkg::CNT_W'(tpi_pkg::CORDIC_STEPS - 1));
  end

  assign out_valid       = ov_r;
  assign out_x_from      = oxf_r;
  assign out_y_from      = oyf_r;
  assign out_x_to        = oxt_r;
  assign out_y_to        = oyt_r;
  assign out_stack_error = oerr_r;

  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= tpi_pkg::LEVEL_W'(tpi_pkg::STACK_DEPTH))
    else $error("stack level beyond depth");
  a_move_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tpi_pkg::OP_MOVE) |=> (ov_r && oerr_r == tpi_pkg::ERR_NONE))
    else $error("segment word not loaded");
  a_push_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == tpi_pkg::OP_PUSH) |=> (lvl_r == $past(lvl_r) + 1'b1))
    else $error("push did not raise level");

endmodule

// ===== test/tpi_scoreboard.sv =====
// Segment predictor and result scoreboard for the turtle path interpreter testbench.
package tpi_tb_pkg;
  import tpi_pkg::*;

  typedef struct packed {
    logic signed [15:0] x_from;
    logic signed [15:0] y_from;
    logic signed [15:0] x_to;
    logic signed [15:0] y_to;
    logic [1:0]         stack_error;
  } segment_t;

  class segment_scoreboard;
    logic [14:0] turn_angle;
    logic [9:0]  step_length;
    logic [11:0] start_x, start_y;
    longint      pos_x, pos_y, step_dx, step_dy;
    int          heading;
    int          level;
    int          saved_px[STACK_DEPTH];
    int          saved_py[STACK_DEPTH];
    int          saved_head[STACK_DEPTH];
    segment_t    pending[$];
    int          errors;

    function new();
      turn_angle = 15'd5760;
      step_length = 10'd10;
      start_x = 12'd960;
      start_y = 12'd540;
      errors = 0;
      restart();
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
      case (idx)
        REG_TURN: turn_angle = data[14:0];
        REG_STEP: step_length = data[9:0];
        REG_STX:  start_x = data[11:0];
        REG_STY:  start_y = data[11:0];
        default: ;
      endcase
    endfunction

    function void restart();
      pos_x = longint'(start_x) * 256;
      pos_y = longint'(start_y) * 256;
      heading = 0;
      step_dx = longint'(step_length) * 256;
      step_dy = 0;
      level = 0;
    endfunction

    // Floor shift, as an arithmetic right shift of a signed value.
    function longint sra(longint v, int s);
      return v >>> s;
    endfunction

    function longint wrap24(longint v);
      logic signed [23:0] w;
      w = v[23:0];
      return longint'(w);
    endfunction

    function longint to_pixel(longint p);
      if (p >= 0) return p >>> 8;
      return -((-p) >>> 8);
    endfunction

    function longint atan_deg(int i);
      longint tbl[24];
      tbl = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return tbl[i];
    endfunction

    function void rotate_step();
      longint z, x, y, xs, ys;
      bit     flip;
      z = longint'(heading) * 1024;
      x = sra(longint'(step_length) * 652032875, 14);
      y = 0;
      flip = 0;
      if (z > 90 * 65536 && z < 270 * 65536) begin
        z -= 180 * 65536;
        flip = 1;
      end else if (z >= 270 * 65536) begin
        z -= 360 * 65536;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = sra(x, i);
        ys = sra(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_deg(i);
        end else begin
          x += ys; y -= xs; z += atan_deg(i);
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      step_dx = sra(x + 128, 8);
      step_dy = sra(y + 128, 8);
    endfunction

    function void note_symbol(logic [7:0] sym, logic nd);
      int       turn;
      segment_t s;
      turn = int'(turn_angle) % 23040;
      s = '0;
      if (nd) restart();
      case (sym)
        CH_FWD: begin
          s.x_from = 16'(to_pixel(pos_x));
          s.y_from = 16'(to_pixel(pos_y));
          pos_x = wrap24(pos_x + step_dx);
          pos_y = wrap24(pos_y + step_dy);
          s.x_to = 16'(to_pixel(pos_x));
          s.y_to = 16'(to_pixel(pos_y));
          s.stack_error = ERR_NONE;
          pending.push_back(s);
        end
        CH_PLUS: begin
          heading = (heading + turn) % 23040;
          rotate_step();
        end
        CH_MINUS: begin
          heading = (heading + 23040 - turn) % 23040;
          rotate_step();
        end
        CH_PUSH: begin
          if (level >= STACK_DEPTH) begin
            s.stack_error = ERR_OVF;
            pending.push_back(s);
          end else begin
            saved_px[level] = int'(to_pixel(pos_x));
            saved_py[level] = int'(to_pixel(pos_y));
            saved_head[level] = heading;
            level++;
          end
        end
        CH_POP: begin
          if (level <= 0) begin
            s.stack_error = ERR_UNF;
            pending.push_back(s);
          end else begin
            level--;
            pos_x = wrap24(longint'(saved_px[level]) * 256);
            pos_y = wrap24(longint'(saved_py[level]) * 256);
            heading = saved_head[level] % 23040;
            rotate_step();
          end
        end
        default: ;
      endcase
    endfunction

    task mismatch(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_segment(segment_t got);
      segment_t want;
      if (pending.size() == 0) begin
        mismatch($sformatf("unexpected word %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.x_from !== want.x_from)
        mismatch($sformatf("x_from %0d want %0d", got.x_from, want.x_from));
      if (got.y_from !== want.y_from)
        mismatch($sformatf("y_from %0d want %0d", got.y_from, want.y_from));
      if (got.x_to !== want.x_to)
        mismatch($sformatf("x_to %0d want %0d", got.x_to, want.x_to));
      if (got.y_to !== want.y_to)
        mismatch($sformatf("y_to %0d want %0d", got.y_to, want.y_to));
      if (got.stack_error !== want.stack_error)
        mismatch($sformatf("stack_error %0d want %0d", got.stack_error, want.stack_error));
    endtask
  endclass
endpackage

// ===== test/tb.sv =====
// Top-level testbench of the turtle path interpreter: stimulus, idling and checking.
module tb;
  import tpi_pkg::*;
  import tpi_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle = 0;
  int   recv_stall = 0;
  bit   hold_off = 0;
  longint cycles = 0;

  tpi_in_if  in_ch();
  tpi_out_if out_ch();
  tpi_cfg_if cfg_ch();

  segment_scoreboard board = new();

  turtle_path_interpreter_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.symbol = 8'd0;
    in_ch.new_drawing = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = 4'd0;
    cfg_ch.wdata = 16'd0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("turtle_path_interpreter_top regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, checking on each accepted word.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_segment({out_ch.x_from, out_ch.y_from, out_ch.x_to, out_ch.y_to,
                           out_ch.stack_error});
    out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // Valid stays up after an accepted word until the next word or an idle cycle
  // replaces it, so each time step sees at most one update of valid.
  task automatic send_symbol(logic [7:0] sym, logic nd);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.symbol <= sym;
    in_ch.new_drawing <= nd;
    do @(posedge clk); while (!in_ch.ready);
    board.note_symbol(sym, nd);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CH_FWD;
    if (r < 55) return CH_PLUS;
    if (r < 68) return CH_MINUS;
    if (r < 80) return CH_PUSH;
    if (r < 92) return CH_POP;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      send_symbol(pick_symbol(), $urandom_range(39) == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: every symbol, a stack underflow, extreme symbols.
    send_symbol(CH_FWD, 1'b0);
    send_symbol(CH_POP, 1'b0);
    send_symbol(CH_PLUS, 1'b0);
    send_symbol(CH_FWD, 1'b0);
    send_symbol(CH_PUSH, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_MINUS, 1'b0);
    send_symbol(CH_FWD, 1'b0);
    send_symbol(CH_POP, 1'b0);
    send_symbol(CH_FWD, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_symbol(CH_FWD, 1'b1);
    drain();

    // Extreme registers: full step, turn just short of a full circle, far start.
    write_reg(REG_TURN, 16'd23039);
    write_reg(REG_STEP, 16'd1023);
    write_reg(REG_STX, 16'd4095);
    write_reg(REG_STY, 16'd0);
    write_reg(4'd9, 16'hFFFF);
    send_symbol(CH_PLUS, 1'b1);
    for (int i = 0; i < 5; i++) send_symbol(CH_FWD, 1'b0);
    for (int i = 0; i < 66; i++) send_symbol(CH_PUSH, 1'b0);
    drain();

    // Receiver holds off long enough to back the block up.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 10; i++) send_symbol(CH_FWD, 1'b0);
    join
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 75; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 75; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      write_reg(REG_TURN, 16'($urandom_range(23039)));
      write_reg(REG_STEP, 16'(phase == 7 ? 0 : $urandom_range(1023)));
      write_reg(REG_STX, 16'($urandom_range(4095)));
      write_reg(REG_STY, 16'($urandom_range(4095)));
      send_symbol(CH_FWD, 1'b1);
      random_run(120);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("turtle_path_interpreter_top regression: pass");
    end else begin
      $display("turtle_path_interpreter_top regression: fail");
    end
    $finish;
  end
endmodule

// ===== turtle_path_interpreter_top.f =====
src/tpi_pkg.sv
src/tpi_if.sv
src/tpi_ctrl.sv
src/tpi_dp.sv
src/turtle_path_interpreter_top.sv
test/tpi_scoreboard.sv
test/tb.sv
